@@ rtl/tosrp_pkg.sv @@
// Shared types, constants and codes for the typed operand stack unit.
package tosrp_pkg;

    // Capacity of the stack and the widths that follow from it.
    localparam int STACK_DEPTH = 256;
    localparam int C_AW        = $clog2(STACK_DEPTH);
    localparam int C_CW        = C_AW + 1;
    // Working width for range checks: holds count, depth and their sums.
    localparam int C_XW        = ((C_CW > 9) ? C_CW : 9) + 2;

    // Operation codes.
    localparam logic [2:0] F_PUSH   = 3'd0;
    localparam logic [2:0] F_POP    = 3'd1;
    localparam logic [2:0] F_DELETE = 3'd2;
    localparam logic [2:0] F_MOVE   = 3'd3;
    localparam logic [2:0] F_COPY   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TYPE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [23:0] length;
    } t_entry;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  kind;
        logic [31:0] address;
        logic [23:0] length;
        logic [8:0]  count;
        logic [7:0]  depth;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [23:0] length;
        logic [1:0]  status;
        logic [8:0]  occupancy;
    } t_result;

    // Port commands from the sequencer to one entry memory.
    typedef struct packed {
        logic            we;
        logic [C_AW-1:0] waddr;
        t_entry          wdata;
        logic [C_AW-1:0] raddr;
    } t_ram_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_STREAM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_SAVE,
        PH_SHIFT,
        PH_RESTORE,
        PH_DUP
    } t_phase;

endpackage

@@ rtl/tosrp_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
module tosrp_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tosrp_ctrl.sv @@
// Sequencer and shared streaming address unit of the operand stack.
module tosrp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tosrp_pkg::t_request i_req,
    output logic                o_idle,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output tosrp_pkg::t_result  o_res,
    output tosrp_pkg::t_ram_cmd o_main_cmd,
    input  tosrp_pkg::t_entry   i_main_rdata,
    output tosrp_pkg::t_ram_cmd o_tmp_cmd,
    input  tosrp_pkg::t_entry   i_tmp_rdata
);

    import tosrp_pkg::*;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    t_request        r_req, n_req;
    t_result         r_res, n_res;
    logic [C_CW-1:0] r_count, n_count;
    logic [C_AW-1:0] r_src, n_src;
    logic [C_AW-1:0] r_dst, n_dst;
    logic [C_CW-1:0] r_left, n_left;
    logic            r_wvalid, n_wvalid;

    logic [C_XW-1:0] w_n, w_cnt, w_dep;
    logic            w_group, w_range_bad, w_copy_full, w_stack_full;
    logic            w_phase_end, w_stream_done;
    logic [C_AW-1:0] w_base;

    assign w_n   = C_XW'(r_count);
    assign w_cnt = C_XW'(r_req.count);
    assign w_dep = C_XW'(r_req.depth);

    assign w_group      = (r_req.func == F_DELETE) || (r_req.func == F_MOVE)
                        || (r_req.func == F_COPY);
    assign w_range_bad  = (w_dep >= w_n) || (w_cnt > (w_dep + C_XW'(1)));
    assign w_copy_full  = (w_n + w_cnt) > C_XW'(STACK_DEPTH);
    assign w_stack_full = (r_count == C_CW'(STACK_DEPTH));
    // Index of the deepest group entry; valid whenever the range check passes.
    assign w_base       = C_AW'(w_n - w_dep - C_XW'(1));

    assign w_phase_end   = (r_left == '0) && !r_wvalid;
    assign w_stream_done = w_phase_end && ((r_phase == PH_RESTORE) || (r_phase == PH_DUP)
                         || ((r_phase == PH_SHIFT) && (r_req.func == F_DELETE)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if ((r_req.func == F_POP) && (r_count != '0)) begin
                    n_state = S_POP;
                end else if (w_group && !w_range_bad && (r_req.count != '0)
                             && !((r_req.func == F_COPY) && w_copy_full)) begin
                    n_state = S_STREAM;
                end
            end
            S_POP: begin
                n_state = S_DONE;
            end
            S_STREAM: begin
                if (w_stream_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory ports and result.
    always_comb begin
        n_phase  = r_phase;
        n_req    = r_req;
        n_res    = r_res;
        n_count  = r_count;
        n_src    = r_src;
        n_dst    = r_dst;
        n_left   = r_left;
        n_wvalid = 1'b0;

        o_main_cmd.we    = 1'b0;
        o_main_cmd.waddr = r_dst;
        o_main_cmd.wdata = i_main_rdata;
        o_main_cmd.raddr = r_src;
        o_tmp_cmd.we     = 1'b0;
        o_tmp_cmd.waddr  = r_dst;
        o_tmp_cmd.wdata  = i_main_rdata;
        o_tmp_cmd.raddr  = r_src;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                end
            end
            S_CHECK: begin
                n_res = '0;
                case (r_req.func)
                    F_PUSH: begin
                        if (w_stack_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_main_cmd.we            = 1'b1;
                            o_main_cmd.waddr         = C_AW'(r_count);
                            o_main_cmd.wdata.kind    = r_req.kind;
                            o_main_cmd.wdata.address = r_req.address;
                            o_main_cmd.wdata.length  = r_req.length;
                            n_count                  = r_count + C_CW'(1);
                        end
                    end
                    F_POP: begin
                        if (r_count == '0) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            o_main_cmd.raddr = C_AW'(r_count - C_CW'(1));
                        end
                    end
                    F_DELETE, F_MOVE, F_COPY: begin
                        if (w_range_bad) begin
                            n_res.status = ST_RANGE;
                        end else if (r_req.count == '0) begin
                            n_res.status = ST_OK;
                        end else if (r_req.func == F_COPY) begin
                            if (w_copy_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_phase = PH_DUP;
                                n_src   = w_base;
                                n_dst   = C_AW'(r_count);
                                n_left  = C_CW'(w_cnt);
                            end
                        end else if (r_req.func == F_MOVE) begin
                            n_phase = PH_SAVE;
                            n_src   = w_base;
                            n_dst   = '0;
                            n_left  = C_CW'(w_cnt);
                        end else begin
                            n_phase = PH_SHIFT;
                            n_src   = C_AW'(C_XW'(w_base) + w_cnt);
                            n_dst   = w_base;
                            n_left  = C_CW'(w_dep + C_XW'(1) - w_cnt);
                        end
                    end
                    default: begin
                        n_res.status = ST_RANGE;
                    end
                endcase
            end
            S_POP: begin
                if (i_main_rdata.kind == r_req.kind) begin
                    n_res.kind    = i_main_rdata.kind;
                    n_res.address = i_main_rdata.address;
                    n_res.length  = i_main_rdata.length;
                    n_count       = r_count - C_CW'(1);
                end else begin
                    n_res.status = ST_TYPE;
                end
            end
            S_STREAM: begin
                // Read side: one entry per cycle.
                if (r_left != '0) begin
                    n_src    = r_src + C_AW'(1);
                    n_left   = r_left - C_CW'(1);
                    n_wvalid = 1'b1;
                end
                // Write side trails the read by the memory latency.
                if (r_wvalid) begin
                    n_dst = r_dst + C_AW'(1);
                    case (r_phase)
                        PH_SAVE: begin
                            o_tmp_cmd.we = 1'b1;
                        end
                        PH_RESTORE: begin
                            o_main_cmd.we    = 1'b1;
                            o_main_cmd.wdata = i_tmp_rdata;
                        end
                        default: begin
                            o_main_cmd.we = 1'b1;
                        end
                    endcase
                end
                if (w_phase_end) begin
                    case (r_phase)
                        PH_SAVE: begin
                            n_phase = PH_SHIFT;
                            n_src   = C_AW'(C_XW'(w_base) + w_cnt);
                            n_dst   = w_base;
                            n_left  = C_CW'(w_dep + C_XW'(1) - w_cnt);
                        end
                        PH_SHIFT: begin
                            if (r_req.func == F_MOVE) begin
                                n_phase = PH_RESTORE;
                                n_src   = '0;
                                n_dst   = C_AW'(w_n - w_cnt);
                                n_left  = C_CW'(w_cnt);
                            end else begin
                                n_count = C_CW'(w_n - w_cnt);
                            end
                        end
                        PH_DUP: begin
                            n_count = C_CW'(w_n + w_cnt);
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_wvalid <= 1'b0;
            r_left   <= '0;
            r_phase  <= PH_SAVE;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wvalid <= n_wvalid;
            r_left   <= n_left;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_src <= n_src;
        r_dst <= n_dst;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res           = r_res;
        o_res.occupancy = 9'(r_count);
    end

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_CW'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_shift_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STREAM) && (r_phase == PH_SHIFT) && r_wvalid && (r_left != '0))
        |-> (r_dst != r_src))
        else $error("shift write collides with pending read");

    a_idle_holds_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !i_start) |=> $stable(r_count))
        else $error("stack count changed while idle");

    a_done_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && i_res_ready) |=> (r_state == S_IDLE))
        else $error("sequencer did not release after result hand-off");
`endif

endmodule

@@ rtl/typed_operand_stack_roll_pick_unit.sv @@
// Top level of the typed operand stack with push, typed pop, group delete, move and copy.
// Push and failed checks go from the check state straight to the result; pop adds a read
// state; a group operation adds one streaming pass per phase over L entries
// (copy: one pass of count; delete: one pass of depth+1-count; move: three passes).
// One request at a time; the next request is accepted in the cycle after the result is registered.
// i_rst_n is synchronous and active low; it empties the stack, and memory contents stay as is.
module typed_operand_stack_roll_pick_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_kind[1:0], entry_address[33:2], entry_length[57:34],
    // group_count[66:58], group_depth[74:67], zero fill [79:75]
    input  logic [79:0] i_s_axis_tdata,
    // func[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // Result channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_kind[1:0], out_address[33:2], out_length[57:34], occupancy[66:58],
    // zero fill [71:67]
    output logic [71:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    import tosrp_pkg::*;

    t_request w_req;
    t_result  w_res;
    t_ram_cmd w_main_cmd, w_tmp_cmd;
    t_entry   w_main_rdata, w_tmp_rdata;
    logic     w_idle, w_start, w_res_valid, w_res_ready;

    logic     r_m_valid;
    t_result  r_m_res;

    // Unpack the request fields from the stream payload.
    assign w_req.func    = i_s_axis_tuser;
    assign w_req.kind    = i_s_axis_tdata[1:0];
    assign w_req.address = i_s_axis_tdata[33:2];
    assign w_req.length  = i_s_axis_tdata[57:34];
    assign w_req.count   = i_s_axis_tdata[66:58];
    assign w_req.depth   = i_s_axis_tdata[74:67];

    // A request is taken only while the sequencer is idle; the sequencer holds its
    // result until the output register can take it.
    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign w_res_ready     = !r_m_valid || i_m_axis_tready;

    tosrp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_req        (w_req),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_main_cmd   (w_main_cmd),
        .i_main_rdata (w_main_rdata),
        .o_tmp_cmd    (w_tmp_cmd),
        .i_tmp_rdata  (w_tmp_rdata)
    );

    // The stack itself.
    tosrp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (w_main_cmd.we),
        .i_waddr (w_main_cmd.waddr),
        .i_wdata (w_main_cmd.wdata),
        .i_raddr (w_main_cmd.raddr),
        .o_rdata (w_main_rdata)
    );

    // Scratch buffer that holds a group while the entries above it slide down.
    tosrp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_tmp_ram (
        .i_clk   (i_clk),
        .i_we    (w_tmp_cmd.we),
        .i_waddr (w_tmp_cmd.waddr),
        .i_wdata (w_tmp_cmd.wdata),
        .i_raddr (w_tmp_cmd.raddr),
        .o_rdata (w_tmp_rdata)
    );

    // Output register: the result stays here until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {5'd0, r_m_res.occupancy, r_m_res.length,
                              r_m_res.address, r_m_res.kind};
    assign o_m_axis_tuser  = r_m_res.status;

endmodule

@@ bench/typed_operand_stack_roll_pick_unit_tb.sv @@
// Self-checking bench for the typed operand stack: directed corner cases, then random traffic.
`timescale 1ns / 100ps

module typed_operand_stack_roll_pick_unit_tb;
    import tosrp_pkg::*;

    // Clock period is 12 ns, split evenly between the high and low halves.
    localparam int HALF_PERIOD    = 6;
    // Cycles with no handshake on either side before the run is declared hung.
    // The limit must cover the slowest request (a move over the whole stack) and the
    // long receiver hold-off, with plenty of margin to spare.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to keep watching the result side once nothing is outstanding.
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;

    // Function codes the block does not define; they must answer with a range error.
    localparam logic [2:0] F_RESERVED  = 3'd5;
    localparam logic [2:0] F_LAST_CODE = 3'd7;

    // Type tags carried by the stack entries.
    typedef enum logic [1:0] {
        K_STRING,
        K_INT_PTR,
        K_SEGMENT,
        K_BOOL_PTR
    } t_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    // Shadow copy of the stack, advanced once per accepted request.
    t_entry  shadow_stack [STACK_DEPTH];
    int      shadow_count = 0;
    t_result expected_stack_results [$];

    int fault_count  = 0;
    int idle_cycles  = 0;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    // A test raises hold_tag to ask the receiver for a hold-off as long as hold_len.
    int hold_len = 0;
    int hold_tag = 0;

    typed_operand_stack_roll_pick_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Applies one request to the shadow stack and returns the result the block must give.
    // Failed checks leave the shadow stack exactly as it was.
    function automatic t_result predict_stack_op(t_request req);
        t_result res;
        t_entry  group_save [STACK_DEPTH];
        int      n;
        int      cnt;
        int      depth;
        int      base;
        res    = '0;
        n      = shadow_count;
        cnt    = int'(req.count);
        depth  = int'(req.depth);
        res.status = ST_OK;
        case (req.func)
            F_PUSH: begin
                if (n >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_stack[n] = {req.kind, req.address, req.length};
                    shadow_count    = n + 1;
                end
            end
            F_POP: begin
                if (n == 0) begin
                    res.status = ST_RANGE;
                end else if (shadow_stack[n-1].kind != req.kind) begin
                    // The popped-entry fields stay zero on a tag mismatch.
                    res.status = ST_TYPE;
                end else begin
                    res.kind     = shadow_stack[n-1].kind;
                    res.address  = shadow_stack[n-1].address;
                    res.length   = shadow_stack[n-1].length;
                    shadow_count = n - 1;
                end
            end
            F_DELETE, F_MOVE, F_COPY: begin
                if (depth >= n || cnt > depth + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    // The group runs upward from its deepest entry at base.
                    base = n - 1 - depth;
                    if (req.func == F_COPY) begin
                        if (n + cnt > STACK_DEPTH) begin
                            res.status = ST_FULL;
                        end else begin
                            for (int k = 0; k < cnt; k++)
                                shadow_stack[n+k] = shadow_stack[base+k];
                            shadow_count = n + cnt;
                        end
                    end else begin
                        // Pull the group out and close the gap; a move puts it back on top.
                        for (int k = 0; k < cnt; k++)
                            group_save[k] = shadow_stack[base+k];
                        for (int k = base; k + cnt < n; k++)
                            shadow_stack[k] = shadow_stack[k+cnt];
                        if (req.func == F_DELETE) begin
                            shadow_count = n - cnt;
                        end else begin
                            for (int k = 0; k < cnt; k++)
                                shadow_stack[n-cnt+k] = group_save[k];
                        end
                    end
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        res.occupancy = shadow_count[8:0];
        return res;
    endfunction

    function automatic t_request make_req(logic [2:0] func, logic [1:0] kind,
                                          logic [31:0] address, logic [23:0] length,
                                          logic [8:0] count, logic [7:0] depth);
        t_request req;
        req.func    = func;
        req.kind    = kind;
        req.address = address;
        req.length  = length;
        req.count   = count;
        req.depth   = depth;
        return req;
    endfunction

    // Picks the next random request from the current shadow stack. Most requests are
    // well formed (valid groups, pops that name the top tag); the rest is raw noise
    // over every field, which also reaches the unused function codes and large counts.
    function automatic t_request next_random_request();
        t_request req;
        int       n;
        int       pick;
        int       push_cut;
        int       depth;
        int       sel;
        n    = shadow_count;
        pick = $urandom_range(99);
        // Near the top of the stack, favor requests that shrink it.
        push_cut = (n > 200) ? 25 : 45;
        req = make_req(F_PUSH, 2'($urandom_range(3)), $urandom, 24'($urandom), 9'd0, 8'd0);
        if (pick < 12) begin
            req.func  = 3'($urandom_range(7));
            req.count = 9'($urandom_range(511));
            req.depth = 8'($urandom_range(255));
        end else if (pick < push_cut || n == 0) begin
            req.func = F_PUSH;
        end else if (pick < push_cut + 20) begin
            req.func = F_POP;
            if ($urandom_range(9) < 8)
                req.kind = shadow_stack[n-1].kind;
        end else begin
            // Mostly shallow groups keep the run short; a few reach deep into the stack.
            if ($urandom_range(19) == 0)
                depth = $urandom_range(n - 1);
            else
                depth = $urandom_range((n - 1 < 7) ? n - 1 : 7);
            req.depth = 8'(depth);
            req.count = 9'($urandom_range(depth + 1));
            sel = $urandom_range(2);
            case (sel)
                0:       req.func = F_DELETE;
                1:       req.func = F_MOVE;
                default: req.func = F_COPY;
            endcase
        end
        return req;
    endfunction

    // Offers one request, idling first as the current phase asks, and records the
    // predicted result once the block accepts it. The valid line is left high so
    // that back-to-back requests need no extra edge.
    task automatic send_request(t_request req);
        bit go;
        go = 1'b0;
        while (!go) begin
            @(negedge clk);
            if ($urandom_range(99) < src_idle_pct)
                s_tvalid <= 1'b0;
            else
                go = 1'b1;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, req.depth, req.count, req.length, req.address, req.kind};
        s_tuser  <= req.func;
        do
            @(posedge clk);
        while (!s_tready);
        expected_stack_results.push_back(predict_stack_op(req));
    endtask

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind      = m_tdata[1:0];
            got.address   = m_tdata[33:2];
            got.length    = m_tdata[57:34];
            got.occupancy = m_tdata[66:58];
            got.status    = m_tuser;
            if (expected_stack_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d address %h length %h status %0d occ %0d",
                             got.kind, got.address, got.length, got.status, got.occupancy);
            end else begin
                want = expected_stack_results.pop_front();
                if (got.kind !== want.kind || got.address !== want.address ||
                    got.length !== want.length || got.status !== want.status ||
                    got.occupancy !== want.occupancy) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $write("result mismatch (expected/actual): kind %0d/%0d address %h/%h ",
                               want.kind, got.kind, want.address, got.address);
                        $display("length %h/%h status %0d/%0d occ %0d/%0d",
                                 want.length, got.length, want.status, got.status,
                                 want.occupancy, got.occupancy);
                    end
                end
            end
        end
    end

    // Receiver: random stalls per cycle, plus an occasional long hold-off that it
    // counts down itself once a test asks for one.
    always @(negedge clk) begin
        int hold_seen;
        int hold_left;
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: ends the run if neither side completes a handshake for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Empty-stack errors, pushes at the field extremes, tag mismatch and a good pop,
    // a small move, an empty group and a count that overreaches its depth.
    task automatic test_small_stack();
        send_request(make_req(F_POP, K_STRING, 0, 24'd0, 9'd0, 8'd0));
        send_request(make_req(F_DELETE, K_STRING, 0, 24'd0, 9'd0, 8'd0));
        send_request(make_req(F_PUSH, K_STRING, 32'h0, 24'h0, 9'd0, 8'd0));
        send_request(make_req(F_PUSH, K_INT_PTR, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'd0, 8'd0));
        send_request(make_req(F_PUSH, K_SEGMENT, $urandom, 24'($urandom), 9'd0, 8'd0));
        send_request(make_req(F_PUSH, K_BOOL_PTR, $urandom, 24'($urandom), 9'd0, 8'd0));
        send_request(make_req(F_POP, K_STRING, 0, 24'd0, 9'd0, 8'd0));
        send_request(make_req(F_POP, K_BOOL_PTR, 0, 24'd0, 9'd0, 8'd0));
        send_request(make_req(F_PUSH, K_BOOL_PTR, $urandom, 24'($urandom), 9'd0, 8'd0));
        send_request(make_req(F_MOVE, K_STRING, 0, 24'd0, 9'd2, 8'd3));
        send_request(make_req(F_DELETE, K_STRING, 0, 24'd0, 9'd0, 8'd2));
        send_request(make_req(F_COPY, K_STRING, 0, 24'd0, 9'd3, 8'd1));
    endtask

    // Doubles the stack by copying all of it until it is full, then checks that
    // both a push and a copy are refused with the full status.
    task automatic test_fill_by_copy();
        while (shadow_count > 0 && shadow_count * 2 <= STACK_DEPTH)
            send_request(make_req(F_COPY, K_STRING, 0, 24'd0, 9'(shadow_count),
                                  8'(shadow_count - 1)));
        send_request(make_req(F_PUSH, K_SEGMENT, $urandom, 24'($urandom), 9'd0, 8'd0));
        send_request(make_req(F_COPY, K_STRING, 0, 24'd0, 9'd1, 8'd0));
    endtask

    // Groups at the deepest depth: rotate the whole stack, lift the bottom entry to
    // the top, then delete everything.
    task automatic test_whole_stack_groups();
        send_request(make_req(F_MOVE, K_STRING, 0, 24'd0, 9'(STACK_DEPTH),
                              8'(STACK_DEPTH - 1)));
        send_request(make_req(F_MOVE, K_STRING, 0, 24'd0, 9'd1, 8'(STACK_DEPTH - 1)));
        send_request(make_req(F_DELETE, K_STRING, 0, 24'd0, 9'(STACK_DEPTH),
                              8'(STACK_DEPTH - 1)));
    endtask

    task automatic test_reserved_codes();
        send_request(make_req(F_RESERVED, K_STRING, 0, 24'd0, 9'd0, 8'd0));
        send_request(make_req(F_LAST_CODE, K_BOOL_PTR, 0, 24'd0, 9'd0, 8'd0));
    endtask

    task automatic test_random_traffic(int requests, int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < requests; i++)
            send_request(next_random_request());
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // requests, so the block backs up and has to stall its request side.
    task automatic test_result_hold_off();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_len      = 300;
        hold_tag++;
        for (int i = 0; i < 40; i++)
            send_request(next_random_request());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_small_stack();
        test_fill_by_copy();
        test_whole_stack_groups();
        test_reserved_codes();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 68, 0);
        test_result_hold_off();
        test_random_traffic(220, 0, 68);
        test_random_traffic(200, 28, 28);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_stack_results.size() != 0)
            @(posedge clk);
        // Any extra result in this window is caught by the checker as unexpected.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
